// ----- sv/hbr_pkg.sv -----
// Shared types and constants of the dual H-bridge ramped drive.
// No dependencies; RTL files but hbr_chk use scoped names, the bench imports it.
`default_nettype none

package hbr_pkg;

   localparam int DUTY_W   = 10;
   localparam int FRAC_W   = 17;
   localparam int GOAL_W   = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int Q_SHIFT  = 16;
   localparam int ROUND_BIAS = 65535;

   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'h10000;

   typedef enum logic [1:0] {
      OP_SET_GOALS = 2'd0,
      OP_SNAP      = 2'd1,
      OP_RAMP      = 2'd2,
      OP_BRAKE     = 2'd3
   } op_type;

   typedef enum logic {
      REG_DRIVE_LIMIT   = 1'b0,
      REG_RAMP_FRACTION = 1'b1
   } reg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] drive_limit;
      logic [FRAC_W-1:0] ramp_fraction;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/hbr_ifs.sv -----
// Item channel interfaces of the dual H-bridge ramped drive: command in, duties out.
// Depends on hbr_pkg for field widths.
`default_nettype none

interface hbr_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         operation;
   logic signed [hbr_pkg::GOAL_W-1:0]  goal_one;
   logic signed [hbr_pkg::GOAL_W-1:0]  goal_two;

   modport source (output valid, output operation, output goal_one, output goal_two,
                   input ready);
   modport sink   (input valid, input operation, input goal_one, input goal_two,
                   output ready);
endinterface

interface hbr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hbr_pkg::DUTY_W-1:0]  duty_one_reverse;
   logic [hbr_pkg::DUTY_W-1:0]  duty_one_forward;
   logic [hbr_pkg::DUTY_W-1:0]  duty_two_reverse;
   logic [hbr_pkg::DUTY_W-1:0]  duty_two_forward;

   modport source (output valid, output duty_one_reverse, output duty_one_forward,
                   output duty_two_reverse, output duty_two_forward, input ready);
   modport sink   (input valid, input duty_one_reverse, input duty_one_forward,
                   input duty_two_reverse, input duty_two_forward, output ready);
endinterface

`default_nettype wire

// ----- sv/hbr_csr.sv -----
// Configuration registers (drive limit, ramp fraction) behind an APB-style port.
// Depends on hbr_pkg.
`default_nettype none

module hbr_csr #(
   parameter int FULL_SCALE = 1023
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [hbr_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [hbr_pkg::CSR_DW-1:0]    pwdata,
   output logic [hbr_pkg::CSR_DW-1:0]         prdata,
   output hbr_pkg::cfg_type                   cfg
);

   localparam int LIM_MAX = (FULL_SCALE > 1023) ? 1023 : FULL_SCALE;
   localparam logic [hbr_pkg::DUTY_W-1:0] LIM_RESET = hbr_pkg::DUTY_W'(LIM_MAX);

   logic [hbr_pkg::DUTY_W-1:0] limit_ff, limit_in;
   logic [hbr_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [hbr_pkg::DUTY_W-1:0] wr_limit;
   logic                       wr_en;
   hbr_pkg::reg_type           sel;

   always_comb begin
      sel      = hbr_pkg::reg_type'(paddr[2]);
      wr_en    = psel && penable && pwrite;
      wr_limit = pwdata[hbr_pkg::DUTY_W-1:0];
      limit_in = limit_ff;
      frac_in  = frac_ff;
      if (wr_en) begin
         unique case (sel)
            hbr_pkg::REG_DRIVE_LIMIT: begin
               limit_in = (wr_limit > LIM_RESET) ? LIM_RESET : wr_limit;
            end
            hbr_pkg::REG_RAMP_FRACTION: begin
               frac_in = pwdata[hbr_pkg::FRAC_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_RESET;
         frac_ff  <= hbr_pkg::FRAC_RESET;
      end else begin
         limit_ff <= limit_in;
         frac_ff  <= frac_in;
      end
   end

   always_comb begin
      unique case (sel)
         hbr_pkg::REG_DRIVE_LIMIT:   prdata = hbr_pkg::CSR_DW'(limit_ff);
         hbr_pkg::REG_RAMP_FRACTION: prdata = hbr_pkg::CSR_DW'(frac_ff);
      endcase
   end

   assign cfg.drive_limit   = limit_ff;
   assign cfg.ramp_fraction = frac_ff;

endmodule

`default_nettype wire

// ----- sv/hbr_axis.sv -----
// One motor: goal and level registers, snap/ramp update with clamp, leg duty mapping.
// Depends on hbr_pkg.
`default_nettype none

module hbr_axis #(
   parameter int FULL_SCALE = 1023
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step_en,
   input  wire hbr_pkg::op_type                     op,
   input  wire logic signed [hbr_pkg::GOAL_W-1:0]   goal,
   input  wire hbr_pkg::cfg_type                    cfg,
   input  wire logic                                braked,
   output logic [hbr_pkg::DUTY_W-1:0]               duty_rev,
   output logic [hbr_pkg::DUTY_W-1:0]               duty_fwd
);

   localparam int LW = $clog2(FULL_SCALE + 1) + 1;
   localparam int GW = ((LW > hbr_pkg::GOAL_W) ? LW : hbr_pkg::GOAL_W) + 1;
   localparam int PW = LW + hbr_pkg::FRAC_W + 2;
   localparam int SW = PW - hbr_pkg::Q_SHIFT + 1;
   localparam int MW = ((LW - 1) > hbr_pkg::DUTY_W) ? (LW - 1) : hbr_pkg::DUTY_W;
   localparam logic [hbr_pkg::DUTY_W-1:0] FS_DUTY = hbr_pkg::DUTY_W'(FULL_SCALE);

   logic signed [LW-1:0] target_ff, target_in;
   logic signed [LW-1:0] level_ff, level_in;
   logic signed [GW-1:0] goal_x, fs_g;
   logic signed [PW-1:0] diff_x, frac_x, prod, biased;
   logic signed [SW-1:0] step_x, sum_x, fs_s;
   logic        [LW-1:0] level_abs;
   logic        [MW-1:0] mag_x, lim_x, drive;

   always_comb begin
      goal_x = GW'(goal);
      fs_g   = GW'(FULL_SCALE);
      priority if (goal_x > fs_g) begin
         target_in = LW'(fs_g);
      end else if (goal_x < -fs_g) begin
         target_in = LW'(-fs_g);
      end else begin
         target_in = LW'(goal_x);
      end
      if (op != hbr_pkg::OP_SET_GOALS) begin
         target_in = target_ff;
      end
   end

   // step = ceil(diff * frac / 2^16), exact for either sign
   always_comb begin
      diff_x = PW'(target_ff) - PW'(level_ff);
      frac_x = PW'({1'b0, cfg.ramp_fraction});
      prod   = diff_x * frac_x;
      biased = prod + PW'(hbr_pkg::ROUND_BIAS);
      step_x = SW'(biased >>> hbr_pkg::Q_SHIFT);
      sum_x  = SW'(level_ff) + step_x;
      fs_s   = SW'(FULL_SCALE);
   end

   always_comb begin
      unique case (op)
         hbr_pkg::OP_SNAP: level_in = target_ff;
         hbr_pkg::OP_RAMP: begin
            priority if (sum_x > fs_s) begin
               level_in = LW'(fs_s);
            end else if (sum_x < -fs_s) begin
               level_in = LW'(-fs_s);
            end else begin
               level_in = LW'(sum_x);
            end
         end
         hbr_pkg::OP_SET_GOALS, hbr_pkg::OP_BRAKE: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         level_ff  <= '0;
      end else if (step_en) begin
         target_ff <= target_in;
         level_ff  <= level_in;
      end
   end

   always_comb begin
      level_abs = level_in[LW-1] ? LW'(-level_in) : LW'(level_in);
      mag_x     = MW'(level_abs[LW-2:0]);
      lim_x     = MW'(cfg.drive_limit);
      drive     = (mag_x > lim_x) ? lim_x : mag_x;
      if (braked) begin
         duty_rev = FS_DUTY;
         duty_fwd = FS_DUTY;
      end else if (level_in[LW-1]) begin
         duty_rev = drive[hbr_pkg::DUTY_W-1:0];
         duty_fwd = '0;
      end else begin
         duty_rev = '0;
         duty_fwd = drive[hbr_pkg::DUTY_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- sv/dual_hbridge_ramped_drive_core.sv -----
// Top level of the dual H-bridge ramped drive: input register, two motor units,
// brake flag, result register. Depends on hbr_pkg, hbr_ifs, hbr_csr, hbr_axis.
//
// Usage:
//   req_ch  : command items (operation, goal_one, goal_two), valid/ready.
//   rsp_ch  : duty items (four leg duties), valid/ready; one per snap or ramp
//             command, none for set-goals or brake toggle.
//   csr_*   : APB-style port, drive_limit at 0x0, ramp_fraction at 0x4.
// Path: an accepted item goes through the input register, the update logic and
//   the result register before its duties appear on rsp_ch.
// Throughput: one item per cycle unless rsp_ch stalls; one multiply, add and
//   clamp per motor lies between the input register and the result register.
// Reset: synchronous; clears goals, levels and brake, empties both registers,
//   drive_limit returns to min(1023, FULL_SCALE), ramp_fraction to 1.0.
// Stall: while a result waits on rsp_ch the input register holds one more
//   item, whether or not that item produces a result. req ready drops only
//   when both registers are full.
`default_nettype none

module dual_hbridge_ramped_drive_core #(
   parameter int FULL_SCALE = 1023
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   hbr_req_if.sink                            req_ch,
   hbr_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [hbr_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [hbr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [hbr_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);

   hbr_pkg::cfg_type cfg;

   logic                               s1_valid_ff, s1_valid_in;
   hbr_pkg::op_type                    s1_op_ff;
   logic signed [hbr_pkg::GOAL_W-1:0]  s1_goal_one_ff, s1_goal_two_ff;
   logic                               braked_ff, braked_in;
   logic                               out_valid_ff, out_valid_in;
   logic [hbr_pkg::DUTY_W-1:0]         d1r_ff, d1f_ff, d2r_ff, d2f_ff;
   logic [hbr_pkg::DUTY_W-1:0]         d1r_in, d1f_in, d2r_in, d2f_in;
   logic                               advance, accept, emit;

   assign csr_pready = 1'b1;

   hbr_csr #(.FULL_SCALE(FULL_SCALE)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   always_comb begin
      advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
      req_ch.ready = !s1_valid_ff || advance;
      accept       = req_ch.valid && req_ch.ready;
      emit         = (s1_op_ff == hbr_pkg::OP_SNAP) || (s1_op_ff == hbr_pkg::OP_RAMP);
      s1_valid_in  = accept || (s1_valid_ff && !advance);
      braked_in    = (advance && (s1_op_ff == hbr_pkg::OP_BRAKE)) ? !braked_ff : braked_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   hbr_axis #(.FULL_SCALE(FULL_SCALE)) u_axis_one (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .op       (s1_op_ff),
      .goal     (s1_goal_one_ff),
      .cfg      (cfg),
      .braked   (braked_ff),
      .duty_rev (d1r_in),
      .duty_fwd (d1f_in)
   );

   hbr_axis #(.FULL_SCALE(FULL_SCALE)) u_axis_two (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .op       (s1_op_ff),
      .goal     (s1_goal_two_ff),
      .cfg      (cfg),
      .braked   (braked_ff),
      .duty_rev (d2r_in),
      .duty_fwd (d2f_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         braked_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         braked_ff    <= braked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= hbr_pkg::op_type'(req_ch.operation);
         s1_goal_one_ff <= req_ch.goal_one;
         s1_goal_two_ff <= req_ch.goal_two;
      end
      if (advance && emit) begin
         d1r_ff <= d1r_in;
         d1f_ff <= d1f_in;
         d2r_ff <= d2r_in;
         d2f_ff <= d2f_in;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.duty_one_reverse = d1r_ff;
   assign rsp_ch.duty_one_forward = d1f_ff;
   assign rsp_ch.duty_two_reverse = d2r_ff;
   assign rsp_ch.duty_two_forward = d2f_ff;

endmodule

`default_nettype wire

// ----- sv/hbr_chk.sv -----
// Port-level checks of the dual H-bridge ramped drive and their bind to the top level.
// Depends on dual_hbridge_ramped_drive_core.
`default_nettype none

module hbr_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [9:0] d1r,
   input wire logic [9:0] d1f,
   input wire logic [9:0] d2r,
   input wire logic [9:0] d2f
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(d1r) && $stable(d1f)
                                  && $stable(d2r) && $stable(d2f))
      else $error("stalled result item changed");

   a_ready_free: assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("input not ready while result side is empty");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result item without an accepted item two edges before");

   // both legs of motor one driven only under brake, then all legs equal
   a_brake_legs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (d1r != 10'd0) && (d1f != 10'd0) |->
         (d1r == d1f) && (d2r == d1r) && (d2f == d1r))
      else $error("both legs driven outside of brake");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind dual_hbridge_ramped_drive_core hbr_chk u_hbr_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .d1r       (rsp_ch.duty_one_reverse),
   .d1f       (rsp_ch.duty_one_forward),
   .d2r       (rsp_ch.duty_two_reverse),
   .d2f       (rsp_ch.duty_two_forward)
);

`default_nettype wire

// ----- bench/tb_dual_hbridge_ramped_drive_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dual_hbridge_ramped_drive_core: queued command items with random
// valid/ready idling, APB register writes, and an in-bench duty predictor with scoreboard.
// Depends on hbr_pkg, hbr_ifs (hbr_req_if, hbr_rsp_if) and the core RTL.

module tb_dual_hbridge_ramped_drive_core;
   import hbr_pkg::*;

   localparam int FULL_SCALE  = 1023;
   localparam int LEVEL_W     = 11;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 4;

   typedef struct {
      op_type                    operation;
      logic signed [GOAL_W-1:0]  goal_one;
      logic signed [GOAL_W-1:0]  goal_two;
   } drive_cmd_t;

   typedef struct packed {
      logic [DUTY_W-1:0] one_rev;
      logic [DUTY_W-1:0] one_fwd;
      logic [DUTY_W-1:0] two_rev;
      logic [DUTY_W-1:0] two_fwd;
   } duty_set_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   hbr_req_if req_ch();
   hbr_rsp_if rsp_ch();

   dual_hbridge_ramped_drive_core #(.FULL_SCALE(FULL_SCALE)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // predictor state and register copies
   logic [DUTY_W-1:0]         drive_cap;
   logic [FRAC_W-1:0]         step_frac;
   logic signed [LEVEL_W-1:0] goal_lvl_one;
   logic signed [LEVEL_W-1:0] goal_lvl_two;
   logic signed [LEVEL_W-1:0] level_one;
   logic signed [LEVEL_W-1:0] level_two;
   logic                      brake_on;

   drive_cmd_t cmd_backlog[$];
   duty_set_t  duty_forecast[$];

   logic req_taken;
   int   stuck_cycles;
   int   mismatch_count = 0;
   int   send_idle_pct = 10;
   int   recv_idle_pct = 66;
   int   hold_req = 0;
   int   hold_seen;
   int   hold_left;

   function automatic logic signed [LEVEL_W-1:0] clamp_level(input longint v);
      if (v > FULL_SCALE) return LEVEL_W'(FULL_SCALE);
      if (v < -FULL_SCALE) return LEVEL_W'(-FULL_SCALE);
      return LEVEL_W'(v);
   endfunction

   function automatic logic signed [LEVEL_W-1:0] ramp_toward(
      input logic signed [LEVEL_W-1:0] lvl, input logic signed [LEVEL_W-1:0] goal);
      longint gap;
      longint step;
      gap = longint'(goal) - longint'(lvl);
      if (gap >= 0)
         step = (gap * longint'(step_frac) + ROUND_BIAS) >>> Q_SHIFT;
      else
         step = -(((-gap) * longint'(step_frac)) >>> Q_SHIFT);
      return clamp_level(longint'(lvl) + step);
   endfunction

   function automatic void split_legs(input logic signed [LEVEL_W-1:0] lvl,
                                      output logic [DUTY_W-1:0] rev,
                                      output logic [DUTY_W-1:0] fwd);
      int mag;
      mag = (lvl < 0) ? -int'(lvl) : int'(lvl);
      if (mag > int'(drive_cap)) mag = int'(drive_cap);
      if (lvl < 0) begin
         rev = mag[DUTY_W-1:0];
         fwd = '0;
      end else begin
         rev = '0;
         fwd = mag[DUTY_W-1:0];
      end
   endfunction

   // returns 1 when the command yields a duty item
   function automatic bit apply_command(input drive_cmd_t cmd, output duty_set_t duties);
      duties = '0;
      case (cmd.operation)
         OP_SET_GOALS: begin
            goal_lvl_one = clamp_level(longint'(cmd.goal_one));
            goal_lvl_two = clamp_level(longint'(cmd.goal_two));
            return 1'b0;
         end
         OP_SNAP: begin
            level_one = goal_lvl_one;
            level_two = goal_lvl_two;
         end
         OP_RAMP: begin
            level_one = ramp_toward(level_one, goal_lvl_one);
            level_two = ramp_toward(level_two, goal_lvl_two);
         end
         default: begin
            brake_on = !brake_on;
            return 1'b0;
         end
      endcase
      if (brake_on) begin
         duties = {4{DUTY_W'(FULL_SCALE)}};
      end else begin
         split_legs(level_one, duties.one_rev, duties.one_fwd);
         split_legs(level_two, duties.two_rev, duties.two_fwd);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input duty_set_t want,
                                  input duty_set_t got);
      mismatch_count++;
      // field order: rev1 fwd1 rev2 fwd2
      if (mismatch_count <= 10)
         $display("ERROR %0t %s: exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time, what,
                  want.one_rev, want.one_fwd, want.two_rev, want.two_fwd,
                  got.one_rev, got.one_fwd, got.two_rev, got.two_fwd);
   endtask

   // scoreboard, predictor and watchdog
   always @(posedge clock) begin
      drive_cmd_t taken;
      duty_set_t  duties;
      duty_set_t  seen;
      if (reset) begin
         req_taken <= 1'b0;
         stuck_cycles <= 0;
         goal_lvl_one = '0;
         goal_lvl_two = '0;
         level_one = '0;
         level_two = '0;
         brake_on = 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.one_rev = rsp_ch.duty_one_reverse;
            seen.one_fwd = rsp_ch.duty_one_forward;
            seen.two_rev = rsp_ch.duty_two_reverse;
            seen.two_fwd = rsp_ch.duty_two_forward;
            if (duty_forecast.size() == 0) begin
               report_mismatch("unexpected item", '0, seen);
            end else begin
               duties = duty_forecast.pop_front();
               if (seen !== duties) report_mismatch("duty mismatch", duties, seen);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.operation = op_type'(req_ch.operation);
            taken.goal_one  = req_ch.goal_one;
            taken.goal_two  = req_ch.goal_two;
            if (apply_command(taken, duties)) duty_forecast.push_back(duties);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // command driver
   always @(negedge clock) begin
      drive_cmd_t next_cmd;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = cmd_backlog.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.operation <= next_cmd.operation;
            req_ch.goal_one  <= next_cmd.goal_one;
            req_ch.goal_two  <= next_cmd.goal_two;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // duty receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_cmd(input op_type op, input logic [GOAL_W-1:0] g1,
                            input logic [GOAL_W-1:0] g2);
      drive_cmd_t cmd;
      cmd.operation = op;
      cmd.goal_one  = g1;
      cmd.goal_two  = g2;
      cmd_backlog.push_back(cmd);
   endtask

   // goals are ignored by everything but set-goals, so they are random noise
   task automatic queue_op(input op_type op);
      queue_cmd(op, GOAL_W'($urandom), GOAL_W'($urandom));
   endtask

   function automatic logic [GOAL_W-1:0] pick_goal();
      case ($urandom_range(5))
         0, 1: return GOAL_W'($urandom);
         2: begin
            case ($urandom_range(5))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return GOAL_W'(FULL_SCALE);
               3: return GOAL_W'(-FULL_SCALE);
               4: return GOAL_W'(FULL_SCALE + 1);
               default: return GOAL_W'(-FULL_SCALE - 1);
            endcase
         end
         default: return GOAL_W'(int'($urandom_range(2200)) - 1100);
      endcase
   endfunction

   task automatic queue_random(input int count);
      int made;
      int roll;
      int burst;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(99);
         if (roll < 22) begin
            queue_cmd(OP_SET_GOALS, pick_goal(), pick_goal());
            made++;
         end else if (roll < 36) begin
            queue_op(OP_SNAP);
            made++;
         end else if (roll < 95) begin
            queue_op(OP_RAMP);
            made++;
         end else begin
            // brake on, up to three updates, brake off
            burst = $urandom_range(3);
            queue_op(OP_BRAKE);
            repeat (burst) queue_op($urandom_range(1) ? OP_RAMP : OP_SNAP);
            queue_op(OP_BRAKE);
            made += burst + 2;
         end
      end
   endtask

   task automatic drain();
      while (cmd_backlog.size() != 0 || req_ch.valid || duty_forecast.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type which, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {which, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (which == REG_DRIVE_LIMIT)
         drive_cap = (data[DUTY_W-1:0] > FULL_SCALE) ? DUTY_W'(FULL_SCALE)
                                                    : data[DUTY_W-1:0];
      else
         step_frac = data[FRAC_W-1:0];
   endtask

   task automatic set_registers(input logic [CSR_DW-1:0] limit_word,
                                input logic [CSR_DW-1:0] frac_word,
                                input int s_idle, input int r_idle);
      drain();
      csr_write(REG_DRIVE_LIMIT, limit_word);
      csr_write(REG_RAMP_FRACTION, frac_word);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.goal_one = '0;
      req_ch.goal_two = '0;
      rsp_ch.ready = 1'b0;
      drive_cap = (1023 > FULL_SCALE) ? DUTY_W'(FULL_SCALE) : DUTY_W'(1023);
      step_frac = FRAC_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: reset levels, clamping, brake, full-step ramp
      queue_op(OP_SNAP);
      queue_cmd(OP_SET_GOALS, 16'h7FFF, 16'h8000);
      queue_op(OP_RAMP);
      queue_cmd(OP_SET_GOALS, 16'hFFFF, 16'h0001);
      queue_op(OP_SNAP);
      queue_op(OP_BRAKE);
      queue_op(OP_RAMP);
      queue_op(OP_SNAP);
      queue_op(OP_BRAKE);
      queue_cmd(OP_SET_GOALS, GOAL_W'(FULL_SCALE), GOAL_W'(-FULL_SCALE));
      queue_op(OP_RAMP);
      queue_cmd(OP_SET_GOALS, GOAL_W'(FULL_SCALE + 1), GOAL_W'(-FULL_SCALE - 1));
      queue_op(OP_SNAP);
      queue_cmd(OP_SET_GOALS, '0, '0);
      queue_op(OP_RAMP);

      // directed: fractional ramp, rounding in both directions
      drain();
      csr_write(REG_RAMP_FRACTION, 32'd21845);
      queue_cmd(OP_SET_GOALS, GOAL_W'(-1000), GOAL_W'(1000));
      repeat (3) queue_op(OP_RAMP);
      queue_cmd(OP_SET_GOALS, GOAL_W'(3), GOAL_W'(-3));
      repeat (2) queue_op(OP_RAMP);
      queue_op(OP_SNAP);

      set_registers(32'd1023, 32'd16384, 10, 66);
      hold_req++;
      queue_random(280);
      set_registers(32'd0, 32'd0, 10, 66);
      queue_random(200);
      set_registers(32'd512, 32'd131071, 10, 66);
      queue_random(280);
      set_registers(32'd300, 32'd1, 66, 10);
      queue_random(140);
      drain();
      queue_random(140);
      set_registers($urandom, $urandom, 66, 10);
      queue_random(280);
      set_registers(32'd1023, 32'd65536, 0, 0);
      queue_random(280);
      set_registers($urandom, $urandom, 0, 0);
      queue_random(280);

      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/hbr_pkg.sv
sv/hbr_ifs.sv
sv/hbr_csr.sv
sv/hbr_axis.sv
sv/dual_hbridge_ramped_drive_core.sv
sv/hbr_chk.sv
bench/tb_dual_hbridge_ramped_drive_core.sv
